>>> hw/rtl/amht_pkg.sv
// Package for the motion history tracker: shared widths, codes and result type.
// No dependencies; imported by the lane modules and the top level.
`default_nettype none

package amht_pkg;

  localparam int AXIS_W  = 16;  // accelerometer axis reading
  localparam int COUNT_W = 6;   // disturbance tally
  localparam int MIN_W   = 13;  // query window bounds in minutes
  localparam int LANE_W  = 32;  // long-history slots scanned by one window lane

  localparam logic [COUNT_W-1:0] TALLY_MAX = '1;
  localparam logic [AXIS_W-1:0]  SENTINEL  = '1;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_QUERY  = 1'b1
  } amht_cmd_e;

  typedef struct packed {
    logic               batch_done;
    logic [COUNT_W-1:0] count;
    logic               batch_moving;
  } amht_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/amht_axis_lane.sv
// One axis lane: absolute difference between previous and current reading
// against the threshold. Depends on amht_pkg.
`default_nettype none

module amht_axis_lane
  import amht_pkg::*;
(
  input  wire logic signed [AXIS_W-1:0] prev_i,
  input  wire logic signed [AXIS_W-1:0] cur_i,
  input  wire logic        [AXIS_W-1:0] thresh_i,
  output logic                          hit_o
);

  logic signed [AXIS_W:0] diff;
  logic        [AXIS_W:0] mag;

  always_comb begin
    diff  = (AXIS_W+1)'(prev_i) - (AXIS_W+1)'(cur_i);
    mag   = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : (AXIS_W+1)'(diff);
    hit_o = mag > {1'b0, thresh_i};
  end

endmodule

`default_nettype wire

>>> hw/rtl/amht_window_lane.sv
// One window lane: checks a chunk of long-history slots against the query
// window [start, end). Depends on amht_pkg.
`default_nettype none

module amht_window_lane
  import amht_pkg::*;
#(
  parameter int IDX_W     = 9,
  parameter int LANE_BASE = 0
) (
  input  wire logic [LANE_W-1:0] slots_i,
  input  wire logic [IDX_W-1:0]  start_i,
  input  wire logic [IDX_W-1:0]  end_i,
  output logic                   hit_o
);

  logic [LANE_W-1:0] mask;

  always_comb begin
    logic [IDX_W-1:0] idx;
    mask = '0;
    for (int j = 0; j < LANE_W; j++) begin
      idx     = IDX_W'(LANE_BASE + j);
      mask[j] = (idx >= start_i) && (idx < end_i);
    end
    hit_o = |(slots_i & mask);
  end

endmodule

`default_nettype wire

>>> hw/rtl/accel_motion_history_tracker_top.sv
// Motion history tracker top: batch state, histories, query pipeline.
// Depends on amht_pkg, amht_axis_lane and amht_window_lane.
//
//   channel   dir  handshake                 payload
//   cfg       in   cfg_we_i                  cfg_wdata_i (move threshold)
//   in        in   in_valid_i / in_stall_o   command, accel xyz, flags, window
//   out       out  out_valid_o / out_stall_i batch_done, count, moving flags
//
// One word per cycle in, one result word per cycle out while the output is not
// stalled; each result passes the request register, then the output register.
// Samples update batch state and histories on accept; a query scans long history
// across the window lanes when it moves from request to output register.
// Reset: previous sample to -1 on every axis, tally and histories zero.
// A stalled output holds the request register, which in turn stalls the input.
`default_nettype none

module accel_motion_history_tracker_top
  import amht_pkg::*;
#(
  parameter int BATCH_SAMPLES    = 32,
  parameter int SHORT_SLOTS      = 30,
  parameter int LONG_SLOTS       = 288,
  parameter int MINUTES_PER_SLOT = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [AXIS_W-1:0]        cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     command_i,
  input  wire logic signed [AXIS_W-1:0] accel_x_i,
  input  wire logic signed [AXIS_W-1:0] accel_y_i,
  input  wire logic signed [AXIS_W-1:0] accel_z_i,
  input  wire logic                     last_in_batch_i,
  input  wire logic                     period_elapsed_i,
  input  wire logic signed [MIN_W-1:0]  start_minutes_i,
  input  wire logic signed [MIN_W-1:0]  end_minutes_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          batch_done_o,
  output logic [COUNT_W-1:0]            disturbance_count_o,
  output logic                          batch_moving_o,
  output logic                          window_moving_o
);

  localparam int NUM_LANES = (LONG_SLOTS + LANE_W - 1) / LANE_W;
  localparam int PAD_W     = NUM_LANES * LANE_W;
  localparam int IDX_W     = $clog2(PAD_W + 1);
  localparam int POS_W     = $clog2(BATCH_SAMPLES + 1);
  localparam int HALF      = SHORT_SLOTS / 2;

  // Divide by minutes per slot through an exact reciprocal for 13-bit values.
  localparam int DIV_N   = MIN_W;
  localparam int DIV_L   = $clog2(MINUTES_PER_SLOT);
  localparam int DIV_SH  = DIV_N + DIV_L;
  localparam int RECIP_W = DIV_N + 2;
  localparam int PROD_W  = DIV_N + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((2 ** DIV_SH) + MINUTES_PER_SLOT - 1) / MINUTES_PER_SLOT);
  localparam int EN_W = MIN_W + 1;
  localparam logic signed [EN_W-1:0] NEG_M  = -EN_W'(MINUTES_PER_SLOT);
  localparam logic signed [EN_W-1:0] ROUND  = EN_W'(MINUTES_PER_SLOT - 1);
  localparam logic [DIV_N-1:0]       LONG_Q = DIV_N'(LONG_SLOTS);

  // Configuration and batch state
  logic [AXIS_W-1:0]      thresh_q;
  logic [2:0][AXIS_W-1:0] prev_q, prev_d;
  logic                   bstart_q, bstart_d;
  logic [COUNT_W-1:0]     tally_q, tally_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [SHORT_SLOTS-1:0] short_q, short_d;
  logic [LONG_SLOTS-1:0]  long_q, long_d;

  // Request stage and output stage
  logic               s1_valid_q, s1_valid_d;
  logic               s1_query_q;
  amht_result_t       s1_res_q, s1_res_d;
  logic [IDX_W-1:0]   s1_start_q, s1_start_d;
  logic [IDX_W-1:0]   s1_end_q, s1_end_d;
  logic               out_valid_q, out_valid_d;
  amht_result_t       out_res_q;
  logic               out_win_q;

  logic in_acc, s1_adv, s1_load, is_sample;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || s1_adv;
  assign in_stall_o = !s1_load;
  assign in_acc     = in_valid_i && s1_load;
  assign is_sample  = amht_cmd_e'(command_i) == CMD_SAMPLE;

  // ---------------- axis lanes and sample update ----------------
  logic [2:0]                    axis_hit;
  logic [2:0][AXIS_W-1:0]        cur;

  assign cur = {accel_z_i, accel_y_i, accel_x_i};

  for (genvar a = 0; a < 3; a++) begin : g_axis
    amht_axis_lane u_axis (
      .prev_i   (prev_q[a]),
      .cur_i    (cur[a]),
      .thresh_i (thresh_q),
      .hit_o    (axis_hit[a])
    );
  end

  logic                   skip, hit_any, closes, moving;
  logic [COUNT_W-1:0]     tally_new;
  logic [POS_W-1:0]       pos_new;
  logic [SHORT_SLOTS-1:0] short_new;
  logic [LONG_SLOTS-1:0]  long_shift;

  always_comb begin
    skip      = bstart_q && (prev_q[0] == SENTINEL) && (prev_q[1] == SENTINEL) &&
                (prev_q[2] == SENTINEL);
    hit_any   = (|axis_hit) && !skip;
    tally_new = tally_q + COUNT_W'(hit_any && (tally_q != TALLY_MAX));
    pos_new   = pos_q + 1'b1;
    closes    = last_in_batch_i || (pos_new == POS_W'(BATCH_SAMPLES));
    moving    = tally_new > COUNT_W'(1);
    short_new = {short_q[SHORT_SLOTS-2:0], moving};
    long_shift = period_elapsed_i ? {long_q[LONG_SLOTS-2:0], 1'b0} : long_q;
    long_shift[0] = |short_new[HALF-1:0];
    long_shift[1] = |short_new[SHORT_SLOTS-1:HALF];

    prev_d   = prev_q;
    bstart_d = bstart_q;
    tally_d  = tally_q;
    pos_d    = pos_q;
    short_d  = short_q;
    long_d   = long_q;
    if (in_acc && is_sample) begin
      prev_d = cur;
      if (closes) begin
        bstart_d = 1'b1;
        tally_d  = '0;
        pos_d    = '0;
        short_d  = short_new;
        long_d   = long_shift;
      end else begin
        bstart_d = 1'b0;
        tally_d  = tally_new;
        pos_d    = pos_new;
      end
    end
  end

  // ---------------- query window bounds ----------------
  logic [DIV_N-1:0]      s_num, e_num, s_quot, e_quot;
  logic [PROD_W-1:0]     s_prod, e_prod;
  logic signed [EN_W-1:0] e_sum;

  always_comb begin
    s_num  = start_minutes_i[MIN_W-1] ? '0 : DIV_N'(start_minutes_i);
    e_sum  = EN_W'(end_minutes_i) + ROUND;
    e_num  = e_sum[EN_W-1] ? '0 : DIV_N'(e_sum);
    s_prod = PROD_W'(s_num) * PROD_W'(RECIP);
    e_prod = PROD_W'(e_num) * PROD_W'(RECIP);
    s_quot = DIV_N'(s_prod >> DIV_SH);
    e_quot = DIV_N'(e_prod >> DIV_SH);

    if (start_minutes_i[MIN_W-1] || (s_quot >= LONG_Q)) begin
      s1_start_d = '0;
    end else begin
      s1_start_d = IDX_W'(s_quot);
    end

    priority if (e_sum <= NEG_M) begin
      s1_end_d = IDX_W'(LONG_SLOTS);
    end else if (e_sum[EN_W-1]) begin
      s1_end_d = '0;
    end else if (e_quot > LONG_Q) begin
      s1_end_d = IDX_W'(LONG_SLOTS);
    end else begin
      s1_end_d = IDX_W'(e_quot);
    end
  end

  always_comb begin
    s1_res_d = '0;
    if (is_sample) begin
      s1_res_d.batch_done   = closes;
      s1_res_d.count        = tally_new;
      s1_res_d.batch_moving = closes && moving;
    end
    s1_valid_d  = s1_load ? in_acc : s1_valid_q;
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  // ---------------- window lanes and merge ----------------
  logic [PAD_W-1:0]     long_pad;
  logic [NUM_LANES-1:0] lane_hit;
  logic                 window_hit;

  assign long_pad = PAD_W'(long_q);

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_win
    amht_window_lane #(
      .IDX_W     (IDX_W),
      .LANE_BASE (l * LANE_W)
    ) u_win (
      .slots_i (long_pad[l*LANE_W +: LANE_W]),
      .start_i (s1_start_q),
      .end_i   (s1_end_q),
      .hit_o   (lane_hit[l])
    );
  end

  assign window_hit = |lane_hit;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= '0;
      prev_q      <= '1;
      bstart_q    <= 1'b1;
      tally_q     <= '0;
      pos_q       <= '0;
      short_q     <= '0;
      long_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      prev_q      <= prev_d;
      bstart_q    <= bstart_d;
      tally_q     <= tally_d;
      pos_q       <= pos_d;
      short_q     <= short_d;
      long_q      <= long_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_query_q <= !is_sample;
      s1_res_q   <= s1_res_d;
      s1_start_q <= s1_start_d;
      s1_end_q   <= s1_end_d;
    end
    // Query reads long history here, before any later word can change it.
    if (s1_valid_q && s1_adv) begin
      out_res_q <= s1_res_q;
      out_win_q <= s1_query_q && window_hit;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign batch_done_o        = out_res_q.batch_done;
  assign disturbance_count_o = out_res_q.count;
  assign batch_moving_o      = out_res_q.batch_moving;
  assign window_moving_o     = out_win_q;

endmodule

`default_nettype wire

>>> hw/rtl/amht_checker.sv
// Port-level checks for the motion history tracker, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module amht_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       batch_done_o,
  input wire logic [5:0] disturbance_count_o,
  input wire logic       batch_moving_o,
  input wire logic       window_moving_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(disturbance_count_o) &&
      $stable(batch_done_o) && $stable(batch_moving_o) && $stable(window_moving_o))
    else $error("stalled result word changed");

  // Input backs up only behind a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_moving_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && batch_moving_o |-> batch_done_o && (disturbance_count_o > 6'd1))
    else $error("moving batch without close or enough disturbances");

  a_query_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_moving_o |-> !batch_done_o && (disturbance_count_o == 6'd0))
    else $error("query answer mixed with sample fields");

endmodule

bind accel_motion_history_tracker_top amht_checker u_amht_checker (.*);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking bench for accel_motion_history_tracker_top: directed and random words.
// Keeps its own motion-history predictor; depends on amht_pkg and the tracker RTL.
`default_nettype none

module testbench;
  import amht_pkg::*;

  localparam int BATCH_SAMPLES    = 32;
  localparam int SHORT_SLOTS      = 30;
  localparam int LONG_SLOTS       = 288;
  localparam int MINUTES_PER_SLOT = 5;
  localparam int TALLY_CAP        = 63;

  typedef struct {
    amht_cmd_e                 command;
    logic signed [AXIS_W-1:0]  axis [3];
    logic                      last;
    logic                      period;
    logic signed [MIN_W-1:0]   start_min;
    logic signed [MIN_W-1:0]   end_min;
  } tracker_word_t;

  typedef struct packed {
    logic               batch_done;
    logic [COUNT_W-1:0] count;
    logic               batch_moving;
    logic               window_moving;
  } tracker_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [AXIS_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     command_i = CMD_SAMPLE;
  logic signed [AXIS_W-1:0] accel_x_i = '0;
  logic signed [AXIS_W-1:0] accel_y_i = '0;
  logic signed [AXIS_W-1:0] accel_z_i = '0;
  logic                     last_in_batch_i = 1'b0;
  logic                     period_elapsed_i = 1'b0;
  logic signed [MIN_W-1:0]  start_minutes_i = '0;
  logic signed [MIN_W-1:0]  end_minutes_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     batch_done_o;
  logic [COUNT_W-1:0]       disturbance_count_o;
  logic                     batch_moving_o;
  logic                     window_moving_o;

  accel_motion_history_tracker_top #(
    .BATCH_SAMPLES   (BATCH_SAMPLES),
    .SHORT_SLOTS     (SHORT_SLOTS),
    .LONG_SLOTS      (LONG_SLOTS),
    .MINUTES_PER_SLOT(MINUTES_PER_SLOT)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .accel_x_i          (accel_x_i),
    .accel_y_i          (accel_y_i),
    .accel_z_i          (accel_z_i),
    .last_in_batch_i    (last_in_batch_i),
    .period_elapsed_i   (period_elapsed_i),
    .start_minutes_i    (start_minutes_i),
    .end_minutes_i      (end_minutes_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .batch_done_o       (batch_done_o),
    .disturbance_count_o(disturbance_count_o),
    .batch_moving_o     (batch_moving_o),
    .window_moving_o    (window_moving_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state, mirrors the tracker after every accepted word
  int                       move_threshold_val = 0;
  logic [AXIS_W-1:0]        prev_axis [3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
  logic                     at_batch_start = 1'b1;
  int                       tally = 0;
  int                       samples_in_batch = 0;
  logic [SHORT_SLOTS-1:0]   short_marks = '0;
  logic [LONG_SLOTS-1:0]    long_marks = '0;

  tracker_result_t pending_results [$];
  int failures = 0;
  int words_sent = 0;
  int tx_gap_max = 0;
  int rx_stall_max = 0;
  int hold_cycles = 0;

  function automatic tracker_result_t track_word(input tracker_word_t w);
    tracker_result_t r;
    int lo_slot;
    int hi_slot;
    int diff;
    logic hit;
    logic moving;
    r = '0;
    if (w.command == CMD_QUERY) begin
      lo_slot = $signed(w.start_min);
      hi_slot = $signed(w.end_min);
      lo_slot = lo_slot / MINUTES_PER_SLOT;
      hi_slot = (hi_slot + MINUTES_PER_SLOT - 1) / MINUTES_PER_SLOT;
      if (lo_slot < 0 || lo_slot >= LONG_SLOTS) lo_slot = 0;
      if (hi_slot < 0 || hi_slot > LONG_SLOTS) hi_slot = LONG_SLOTS;
      for (int i = lo_slot; i < hi_slot; i++) begin
        if (long_marks[i]) r.window_moving = 1'b1;
      end
      return r;
    end
    // skip the compare on the first sample of a batch after a sentinel sample
    if (!(at_batch_start && prev_axis[0] == SENTINEL && prev_axis[1] == SENTINEL &&
          prev_axis[2] == SENTINEL)) begin
      hit = 1'b0;
      for (int a = 0; a < 3; a++) begin
        diff = int'($signed(prev_axis[a])) - int'(w.axis[a]);
        if (diff < 0) diff = -diff;
        if (diff > move_threshold_val) hit = 1'b1;
      end
      if (hit && tally < TALLY_CAP) tally++;
    end
    at_batch_start = 1'b0;
    for (int a = 0; a < 3; a++) prev_axis[a] = w.axis[a];
    if (samples_in_batch < BATCH_SAMPLES) samples_in_batch++;
    r.count = tally[COUNT_W-1:0];
    if (w.last || samples_in_batch >= BATCH_SAMPLES) begin
      moving = tally > 1;
      short_marks = {short_marks[SHORT_SLOTS-2:0], moving};
      if (w.period) long_marks = {long_marks[LONG_SLOTS-2:0], 1'b0};
      long_marks[0] = |short_marks[SHORT_SLOTS/2-1:0];
      long_marks[1] = |short_marks[SHORT_SLOTS-1:SHORT_SLOTS/2];
      r.batch_done = 1'b1;
      r.batch_moving = moving;
      tally = 0;
      samples_in_batch = 0;
      at_batch_start = 1'b1;
    end
    return r;
  endfunction

  task automatic send_word(input tracker_word_t w);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    command_i        <= w.command;
    accel_x_i        <= w.axis[0];
    accel_y_i        <= w.axis[1];
    accel_z_i        <= w.axis[2];
    last_in_batch_i  <= w.last;
    period_elapsed_i <= w.period;
    start_minutes_i  <= w.start_min;
    end_minutes_i    <= w.end_min;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(track_word(w));
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_move_threshold(input int value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[AXIS_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    move_threshold_val = value;
  endtask

  function automatic tracker_word_t sample_word(input int x, input int y, input int z,
                                                input logic last, input logic period);
    tracker_word_t w;
    w.command   = CMD_SAMPLE;
    w.axis[0]   = x[AXIS_W-1:0];
    w.axis[1]   = y[AXIS_W-1:0];
    w.axis[2]   = z[AXIS_W-1:0];
    w.last      = last;
    w.period    = period;
    w.start_min = MIN_W'($urandom);
    w.end_min   = MIN_W'($urandom);
    return w;
  endfunction

  function automatic tracker_word_t query_word(input int start_min, input int end_min);
    tracker_word_t w;
    w = sample_word($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    w.command   = CMD_QUERY;
    w.start_min = start_min[MIN_W-1:0];
    w.end_min   = end_min[MIN_W-1:0];
    return w;
  endfunction

  function automatic int window_bound();
    case ($urandom_range(0, 11))
      0:       return -4096;
      1:       return -9;
      2:       return -5;
      3:       return -1;
      4:       return 0;
      5:       return 4;
      6:       return 5;
      7:       return 1435;
      8:       return 1436;
      9:       return 1439;
      10:      return 1440;
      default: return 4095;
    endcase
  endfunction

  function automatic tracker_word_t random_query();
    case ($urandom_range(0, 3))
      0:       return query_word($urandom, $urandom);
      1:       return query_word(window_bound(), window_bound());
      default: return query_word($urandom_range(0, 1500), $urandom_range(0, 1500));
    endcase
  endfunction

  // Next axis reading: mostly close to the last one, straddling the threshold
  function automatic int next_axis(input logic [AXIS_W-1:0] base);
    int span;
    span = (move_threshold_val + 2 > 32767) ? 32767 : move_threshold_val + 2;
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return -1;
      2, 3:    return int'($signed(base)) + $urandom_range(0, 6) - 3;
      default: return int'($signed(base)) + $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic tracker_word_t random_sample(input logic last);
    if ($urandom_range(0, 24) == 0)
      return sample_word(-1, -1, -1, last, 1'($urandom_range(0, 1)));
    return sample_word(next_axis(prev_axis[0]), next_axis(prev_axis[1]),
                       next_axis(prev_axis[2]), last, 1'($urandom_range(0, 1)));
  endfunction

  // One batch: mostly short and well formed, sometimes overlong or unterminated
  task automatic random_batch();
    int len;
    logic last;
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(BATCH_SAMPLES, BATCH_SAMPLES + 8);
      1, 2:    len = $urandom_range(7, BATCH_SAMPLES - 1);
      default: len = $urandom_range(1, 6);
    endcase
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(random_query());
      last = (i == len - 1) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
      send_word(random_sample(last));
    end
  endtask

  task automatic test_empty_history();
    send_word(query_word(-4096, 4095));
    send_word(query_word(0, 1440));
  endtask

  task automatic test_sentinel_skip();
    // first word after reset is not compared against the sentinel
    send_word(sample_word(-32768, 32767, 0, 1'b0, 1'b0));
    send_word(sample_word(32767, -32768, -1, 1'b0, 1'b0));
    // period flag on a word that does not close the batch
    send_word(sample_word(32767, -32768, -1, 1'b0, 1'b1));
    send_word(sample_word(-1, -1, -1, 1'b1, 1'b1));
    send_word(sample_word(5, 5, 5, 1'b0, 1'b0));
    send_word(sample_word(5, 5, 5, 1'b0, 1'b0));
    send_word(sample_word(5, 5, 6, 1'b1, 1'b0));
  endtask

  task automatic test_threshold_extremes();
    set_move_threshold(65534);
    send_word(sample_word(-32768, 0, 0, 1'b0, 1'b0));
    send_word(sample_word(32767, 0, 0, 1'b0, 1'b0));
    set_move_threshold(65535);
    send_word(sample_word(-32768, 0, 0, 1'b1, 1'b1));
    set_move_threshold(0);
  endtask

  task automatic test_query_windows();
    send_word(query_word(0, 5));
    send_word(query_word(5, 10));
    send_word(query_word(0, 0));
    send_word(query_word(-1, 4));
    send_word(query_word(-9, -9));
    send_word(query_word(4, -4));
    send_word(query_word(1440, 5));
    send_word(query_word(10, 5));
    send_word(query_word(1439, 1440));
    send_word(query_word(4095, -4096));
  endtask

  task automatic test_overlong_batch();
    drain_results();
    for (int i = 0; i < BATCH_SAMPLES + 8; i++) send_word(random_sample(1'b0));
  endtask

  task automatic test_input_backpressure();
    drain_results();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    hold_cycles  = 120;
    for (int i = 0; i < 60; i++) send_word(random_sample($urandom_range(0, 7) == 0));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int thr, input int gap_max,
                                     input int stall_max);
    int target;
    set_move_threshold(thr);
    tx_gap_max   = gap_max;
    rx_stall_max = stall_max;
    target = words_sent + count;
    while (words_sent < target) random_batch();
  endtask

  task automatic check_result();
    tracker_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing pending: batch_done %0d count %0d", batch_done_o,
             disturbance_count_o);
      failures++;
    end else begin
      want = pending_results.pop_front();
      if (want.batch_done !== batch_done_o) begin
        $error("batch_done: expected %0d, actual %0d", want.batch_done, batch_done_o);
        failures++;
      end
      if (want.count !== disturbance_count_o) begin
        $error("disturbance_count: expected %0d, actual %0d", want.count,
               disturbance_count_o);
        failures++;
      end
      if (want.batch_moving !== batch_moving_o) begin
        $error("batch_moving: expected %0d, actual %0d", want.batch_moving, batch_moving_o);
        failures++;
      end
      if (want.window_moving !== window_moving_o) begin
        $error("window_moving: expected %0d, actual %0d", want.window_moving,
               window_moving_o);
        failures++;
      end
    end
  endtask

  // Receiver: random stall per word, plus one long hold-off on request
  initial begin : result_side
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = $urandom_range(0, rx_stall_max);
      end
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      check_result();
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_gap_max   = 2;
    rx_stall_max = 2;
    test_empty_history();
    test_sentinel_skip();
    test_threshold_extremes();
    test_query_windows();
    test_overlong_batch();
    test_input_backpressure();
    test_random_traffic(230, 0, 4, 4);
    test_random_traffic(230, 65535, 0, 0);
    test_random_traffic(230, 200, 4, 0);
    test_random_traffic(230, $urandom_range(0, 65535), 0, 4);
    test_random_traffic(230, 3, 2, 2);
    drain_results();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/amht_pkg.sv
hw/rtl/amht_axis_lane.sv
hw/rtl/amht_window_lane.sv
hw/rtl/accel_motion_history_tracker_top.sv
hw/rtl/amht_checker.sv
sim/testbench.sv
